>>> hw/rtl/sssd_pkg.sv
package sssd_pkg;

  localparam int CW     = 16;          // coordinate width, signed Q8.8
  localparam int VW     = CW + 1;      // difference vector component
  localparam int PW     = 2 * VW;      // component product
  localparam int DW     = PW + 2;      // dot product, sum of three
  localparam int PSPLIT = DW / 2;      // split point of the wide products
  localparam int PPW    = PSPLIT + 1 + DW; // partial product width
  localparam int WW     = 74;          // numerators, denominators, units 2^-32
  localparam int QW     = 16;          // fraction bits of s and t
  localparam int SW     = QW + 1;      // s and t, 0 .. 1.0
  localparam int SUW    = SW + 1 + VW; // s*u product
  localparam int CMW    = 37;          // difference component, units 2^-24
  localparam int MW     = CMW - 8;     // rounded magnitude, units 2^-16
  localparam int SQW    = 2 * MW;
  localparam int SUMW   = SQW + 2;
  localparam int OUT_W  = 34;
  localparam int TW     = 32;          // threshold register width

  localparam logic [TW-1:0]    PAR_THR_RST = 32'd4295;
  localparam logic [TW-1:0]    NZ_THR_RST  = 32'd4295;
  localparam logic [OUT_W-1:0] OUT_MAX     = '1;
  localparam logic [WW-1:0]    ONE_Q32     = WW'(64'h1_0000_0000);
  localparam logic [SW-1:0]    FRAC_ONE    = SW'(65536);

  typedef enum logic {
    REG_PAR_THR = 1'b0,
    REG_NZ_THR  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [2:0][VW-1:0] u;
    logic [2:0][VW-1:0] v;
    logic [2:0][VW-1:0] w;
  } geo_t;

  typedef struct packed {
    logic [DW-1:0] uu;
    logic [DW-1:0] uv;
    logic [DW-1:0] vv;
    logic [DW-1:0] uw;
    logic [DW-1:0] vw;
  } dots_t;

  typedef struct packed {
    logic [WW-1:0] rem;
    logic [WW-1:0] den;
    logic [QW-1:0] q;
    logic          frc;  // result known before the divide
    logic          one;  // forced result is 1.0, else 0
  } frac_t;

endpackage

>>> hw/rtl/segment_segment_squared_distance_unit.sv
// Squared closest distance between two 3D segments.
//
// Input channel: in_valid/in_ready with the four end points as signed Q8.8.
// Result channel: out_valid/out_ready with out_squared_distance, unsigned
// Q18.16. Configuration: APB-style port, parallel_threshold at address 0,
// near_zero_threshold at address 4, both 32 bits, units of 2^-32.
//
// One pair is accepted per cycle while in_ready is high: every stage is
// registered, the wide products are split in halves over two stages and
// each fraction is a 16-stage restoring divider, one quotient bit per
// stage.
//
// Each stage holds a valid bit and advances when the stage after it is
// empty or advancing, so bubbles close up and in_ready stays high while a
// result waits at the output as long as some stage is empty. in_ready falls
// only when all 29 stages hold items.
//
// Reset (rst_n low, synchronous) empties the pipeline and loads both
// thresholds with 4295.
module segment_segment_squared_distance_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_start_x,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_start_y,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_start_z,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_end_x,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_end_y,
  input  logic signed [sssd_pkg::CW-1:0]   in_first_end_z,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_start_x,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_start_y,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_start_z,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_end_x,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_end_y,
  input  logic signed [sssd_pkg::CW-1:0]   in_second_end_z,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [sssd_pkg::OUT_W-1:0]       out_squared_distance,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int ST_DIFF  = 1;
  localparam int ST_MUL   = 2;
  localparam int ST_DOT   = 3;
  localparam int ST_PP    = 4;
  localparam int ST_PROD  = 5;
  localparam int ST_NUM   = 6;
  localparam int ST_SEL   = 7;
  localparam int ST_CLAMP = 8;
  localparam int ST_PRE   = 9;
  localparam int ST_SCALE = ST_PRE + sssd_pkg::QW + 1;
  localparam int ST_CVEC  = ST_SCALE + 1;
  localparam int ST_SQ    = ST_CVEC + 1;
  localparam int NS       = ST_SQ + 1;

  localparam int WW  = sssd_pkg::WW;
  localparam int DW  = sssd_pkg::DW;
  localparam int VW  = sssd_pkg::VW;
  localparam int QW  = sssd_pkg::QW;
  localparam int CMW = sssd_pkg::CMW;
  localparam int MW  = sssd_pkg::MW;

  // configuration
  logic [sssd_pkg::TW-1:0] par_thr_r;
  logic [sssd_pkg::TW-1:0] nz_thr_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      par_thr_r <= sssd_pkg::PAR_THR_RST;
      nz_thr_r  <= sssd_pkg::NZ_THR_RST;
    end else if (psel && penable && pwrite) begin
      case (sssd_pkg::reg_idx_t'(paddr[2]))
        sssd_pkg::REG_PAR_THR: par_thr_r <= pwdata;
        sssd_pkg::REG_NZ_THR:  nz_thr_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sssd_pkg::reg_idx_t'(paddr[2]))
      sssd_pkg::REG_PAR_THR: prdata = par_thr_r;
      sssd_pkg::REG_NZ_THR:  prdata = nz_thr_r;
      default:               prdata = '0;
    endcase
  end

  // pipeline control
  logic [NS:1]   vld_r;
  logic [NS+1:1] adv;

  always_comb begin
    adv[NS+1] = out_ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = vld_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[1]) begin
        vld_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // stage 1: difference vectors
  sssd_pkg::geo_t geo_r [ST_DIFF:ST_SCALE];

  always_ff @(posedge clk) begin
    if (adv[ST_DIFF]) begin
      geo_r[ST_DIFF].u[0] <= VW'(in_first_end_x) - VW'(in_first_start_x);
      geo_r[ST_DIFF].u[1] <= VW'(in_first_end_y) - VW'(in_first_start_y);
      geo_r[ST_DIFF].u[2] <= VW'(in_first_end_z) - VW'(in_first_start_z);
      geo_r[ST_DIFF].v[0] <= VW'(in_second_end_x) - VW'(in_second_start_x);
      geo_r[ST_DIFF].v[1] <= VW'(in_second_end_y) - VW'(in_second_start_y);
      geo_r[ST_DIFF].v[2] <= VW'(in_second_end_z) - VW'(in_second_start_z);
      geo_r[ST_DIFF].w[0] <= VW'(in_first_start_x) - VW'(in_second_start_x);
      geo_r[ST_DIFF].w[1] <= VW'(in_first_start_y) - VW'(in_second_start_y);
      geo_r[ST_DIFF].w[2] <= VW'(in_first_start_z) - VW'(in_second_start_z);
    end
  end

  for (genvar k = ST_DIFF + 1; k <= ST_SCALE; k++) begin : g_geo
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        geo_r[k] <= geo_r[k-1];
      end
    end
  end

  // stage 2: component products
  logic signed [sssd_pkg::PW-1:0] puu_r [3];
  logic signed [sssd_pkg::PW-1:0] puv_r [3];
  logic signed [sssd_pkg::PW-1:0] pvv_r [3];
  logic signed [sssd_pkg::PW-1:0] puw_r [3];
  logic signed [sssd_pkg::PW-1:0] pvw_r [3];

  always_ff @(posedge clk) begin
    if (adv[ST_MUL]) begin
      for (int i = 0; i < 3; i++) begin
        puu_r[i] <= $signed(geo_r[ST_DIFF].u[i]) * $signed(geo_r[ST_DIFF].u[i]);
        puv_r[i] <= $signed(geo_r[ST_DIFF].u[i]) * $signed(geo_r[ST_DIFF].v[i]);
        pvv_r[i] <= $signed(geo_r[ST_DIFF].v[i]) * $signed(geo_r[ST_DIFF].v[i]);
        puw_r[i] <= $signed(geo_r[ST_DIFF].u[i]) * $signed(geo_r[ST_DIFF].w[i]);
        pvw_r[i] <= $signed(geo_r[ST_DIFF].v[i]) * $signed(geo_r[ST_DIFF].w[i]);
      end
    end
  end

  // stage 3: dot products
  sssd_pkg::dots_t dot_r [ST_DOT:ST_SEL];

  always_ff @(posedge clk) begin
    if (adv[ST_DOT]) begin
      dot_r[ST_DOT].uu <= DW'(puu_r[0]) + DW'(puu_r[1]) + DW'(puu_r[2]);
      dot_r[ST_DOT].uv <= DW'(puv_r[0]) + DW'(puv_r[1]) + DW'(puv_r[2]);
      dot_r[ST_DOT].vv <= DW'(pvv_r[0]) + DW'(pvv_r[1]) + DW'(pvv_r[2]);
      dot_r[ST_DOT].uw <= DW'(puw_r[0]) + DW'(puw_r[1]) + DW'(puw_r[2]);
      dot_r[ST_DOT].vw <= DW'(pvw_r[0]) + DW'(pvw_r[1]) + DW'(pvw_r[2]);
    end
  end

  for (genvar k = ST_DOT + 1; k <= ST_SEL; k++) begin : g_dot
    always_ff @(posedge clk) begin
      if (adv[k]) begin
        dot_r[k] <= dot_r[k-1];
      end
    end
  end

  // stage 4: wide products as two half products each
  // order: uu*vv, uv*uv, uv*vw, vv*uw, uu*vw, uv*uw
  logic signed [DW-1:0] ma [6];
  logic signed [DW-1:0] mb [6];
  logic signed [sssd_pkg::PPW-1:0] phi_r [6];
  logic signed [sssd_pkg::PPW-1:0] plo_r [6];

  always_comb begin
    ma[0] = $signed(dot_r[ST_DOT].uu); mb[0] = $signed(dot_r[ST_DOT].vv);
    ma[1] = $signed(dot_r[ST_DOT].uv); mb[1] = $signed(dot_r[ST_DOT].uv);
    ma[2] = $signed(dot_r[ST_DOT].uv); mb[2] = $signed(dot_r[ST_DOT].vw);
    ma[3] = $signed(dot_r[ST_DOT].vv); mb[3] = $signed(dot_r[ST_DOT].uw);
    ma[4] = $signed(dot_r[ST_DOT].uu); mb[4] = $signed(dot_r[ST_DOT].vw);
    ma[5] = $signed(dot_r[ST_DOT].uv); mb[5] = $signed(dot_r[ST_DOT].uw);
  end

  always_ff @(posedge clk) begin
    if (adv[ST_PP]) begin
      for (int i = 0; i < 6; i++) begin
        phi_r[i] <= $signed(ma[i][DW-1:sssd_pkg::PSPLIT]) * mb[i];
        plo_r[i] <= $signed({1'b0, ma[i][sssd_pkg::PSPLIT-1:0]}) * mb[i];
      end
    end
  end

  // stage 5: full products
  logic signed [WW-1:0] prod_r [6];

  always_ff @(posedge clk) begin
    if (adv[ST_PROD]) begin
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= (WW'(phi_r[i]) <<< sssd_pkg::PSPLIT) + WW'(plo_r[i]);
      end
    end
  end

  // stage 6: determinant and line numerators
  logic signed [WW-1:0] e_r;
  logic signed [WW-1:0] sn6_r;
  logic signed [WW-1:0] tn6_r;

  always_ff @(posedge clk) begin
    if (adv[ST_NUM]) begin
      e_r   <= prod_r[0] - prod_r[1];
      sn6_r <= prod_r[2] - prod_r[3];
      tn6_r <= prod_r[4] - prod_r[5];
    end
  end

  // stage 7: parallel test and clamp of s
  logic signed [WW-1:0] sn7_nxt, sd7_nxt, tn7_nxt, td7_nxt;
  logic signed [WW-1:0] sn7_r, sd7_r, tn7_r, td7_r;
  logic signed [WW-1:0] pthr;
  logic signed [WW-1:0] vw_q6, vv_q6, vwuv_q6;

  always_comb begin
    pthr    = WW'(par_thr_r);
    vw_q6   = WW'($signed(dot_r[ST_NUM].vw)) <<< 16;
    vv_q6   = WW'($signed(dot_r[ST_NUM].vv)) <<< 16;
    vwuv_q6 = (WW'($signed(dot_r[ST_NUM].vw)) + WW'($signed(dot_r[ST_NUM].uv))) <<< 16;
    sn7_nxt = sn6_r;
    sd7_nxt = e_r;
    tn7_nxt = tn6_r;
    td7_nxt = e_r;
    if (e_r < pthr) begin
      sn7_nxt = '0;
      sd7_nxt = sssd_pkg::ONE_Q32;
      tn7_nxt = vw_q6;
      td7_nxt = vv_q6;
    end else if (sn6_r < 0) begin
      sn7_nxt = '0;
      tn7_nxt = vw_q6;
      td7_nxt = vv_q6;
    end else if (e_r < sn6_r) begin
      sn7_nxt = e_r;
      tn7_nxt = vwuv_q6;
      td7_nxt = vv_q6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SEL]) begin
      sn7_r <= sn7_nxt;
      sd7_r <= sd7_nxt;
      tn7_r <= tn7_nxt;
      td7_r <= td7_nxt;
    end
  end

  // stage 8: clamp of t, refit s against the chosen end
  logic signed [WW-1:0] sn8_nxt, sd8_nxt, tn8_nxt;
  logic signed [WW-1:0] sn8_r, sd8_r, tn8_r, td8_r;
  logic signed [DW:0]   refit_m;
  logic signed [DW:0]   uu7;
  logic                 do_refit;

  always_comb begin
    uu7      = (DW+1)'($signed(dot_r[ST_SEL].uu));
    sn8_nxt  = sn7_r;
    sd8_nxt  = sd7_r;
    tn8_nxt  = tn7_r;
    do_refit = 1'b0;
    refit_m  = -(DW+1)'($signed(dot_r[ST_SEL].uw));
    if (tn7_r < 0) begin
      tn8_nxt  = '0;
      do_refit = 1'b1;
    end else if (td7_r < tn7_r) begin
      tn8_nxt  = td7_r;
      do_refit = 1'b1;
      refit_m  = (DW+1)'($signed(dot_r[ST_SEL].uv)) - (DW+1)'($signed(dot_r[ST_SEL].uw));
    end
    if (do_refit) begin
      if (refit_m < 0) begin
        sn8_nxt = '0;
      end else if (refit_m > uu7) begin
        sn8_nxt = sd7_r;
      end else begin
        sn8_nxt = WW'(refit_m) <<< 16;
        sd8_nxt = WW'(uu7) <<< 16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_CLAMP]) begin
      sn8_r <= sn8_nxt;
      sd8_r <= sd8_nxt;
      tn8_r <= tn8_nxt;
      td8_r <= td7_r;
    end
  end

  // stage 9: snap, range checks; stages 10..25: one quotient bit each
  function automatic sssd_pkg::frac_t frac_pre(input logic signed [WW-1:0] num,
                                               input logic signed [WW-1:0] den,
                                               input logic [sssd_pkg::TW-1:0] thr);
    sssd_pkg::frac_t r;
    logic [WW-1:0] mag;
    mag   = (num < 0) ? WW'(-num) : WW'(num);
    r.rem = num;
    r.den = den;
    r.q   = '0;
    r.frc = 1'b1;
    r.one = 1'b0;
    if (mag < WW'(thr)) begin
      r.one = 1'b0;
    end else if (den <= 0) begin
      r.one = 1'b0;
    end else if (num < 0) begin
      r.one = 1'b0;
    end else if (!(num < den)) begin
      r.one = 1'b1;
    end else begin
      r.frc = 1'b0;
    end
    return r;
  endfunction

  function automatic sssd_pkg::frac_t frac_step(input sssd_pkg::frac_t a);
    sssd_pkg::frac_t r;
    logic [WW:0] r2;
    r  = a;
    r2 = {a.rem, 1'b0};
    if (r2 >= {1'b0, a.den}) begin
      r.rem = WW'(r2 - {1'b0, a.den});
      r.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      r.rem = r2[WW-1:0];
      r.q   = {a.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  sssd_pkg::frac_t sdv_r [0:QW];
  sssd_pkg::frac_t tdv_r [0:QW];

  always_ff @(posedge clk) begin
    if (adv[ST_PRE]) begin
      sdv_r[0] <= frac_pre(sn8_r, sd8_r, nz_thr_r);
      tdv_r[0] <= frac_pre(tn8_r, td8_r, nz_thr_r);
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv[ST_PRE+i]) begin
        sdv_r[i] <= frac_step(sdv_r[i-1]);
        tdv_r[i] <= frac_step(tdv_r[i-1]);
      end
    end
  end

  // stage 26: s*u and t*v
  logic [sssd_pkg::SW-1:0] s_val, t_val;
  logic signed [sssd_pkg::SUW-1:0] su_r [3];
  logic signed [sssd_pkg::SUW-1:0] tv_r [3];

  always_comb begin
    s_val = sdv_r[QW].frc ? (sdv_r[QW].one ? sssd_pkg::FRAC_ONE : '0)
                          : {1'b0, sdv_r[QW].q};
    t_val = tdv_r[QW].frc ? (tdv_r[QW].one ? sssd_pkg::FRAC_ONE : '0)
                          : {1'b0, tdv_r[QW].q};
  end

  always_ff @(posedge clk) begin
    if (adv[ST_SCALE]) begin
      for (int i = 0; i < 3; i++) begin
        su_r[i] <= $signed({1'b0, s_val}) * $signed(geo_r[ST_SCALE-1].u[i]);
        tv_r[i] <= $signed({1'b0, t_val}) * $signed(geo_r[ST_SCALE-1].v[i]);
      end
    end
  end

  // stage 27: difference components, magnitude rounded to units 2^-16
  logic signed [CMW-1:0] cvec [3];
  logic [CMW-1:0]        cmag [3];
  logic [CMW-1:0]        crnd [3];
  logic [MW-1:0]         m_r  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cvec[i] = (CMW'($signed(geo_r[ST_SCALE].w[i])) <<< 16) + CMW'(su_r[i])
                - CMW'(tv_r[i]);
      cmag[i] = (cvec[i] < 0) ? CMW'(-cvec[i]) : CMW'(cvec[i]);
      crnd[i] = cmag[i] + CMW'(128);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[ST_CVEC]) begin
      for (int i = 0; i < 3; i++) begin
        m_r[i] <= crnd[i][CMW-1:8];
      end
    end
  end

  // stage 28: squares
  logic [sssd_pkg::SQW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (adv[ST_SQ]) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= m_r[i] * m_r[i];
      end
    end
  end

  // stage 29: sum, round to Q18.16, saturate
  logic [sssd_pkg::SUMW-1:0] sum_w;
  logic [sssd_pkg::SUMW-1:0] sum_rnd;
  logic [sssd_pkg::OUT_W-1:0] dist_nxt;
  logic [sssd_pkg::OUT_W-1:0] dist_r;

  always_comb begin
    sum_w   = sssd_pkg::SUMW'(sq_r[0]) + sssd_pkg::SUMW'(sq_r[1])
              + sssd_pkg::SUMW'(sq_r[2]);
    sum_rnd = (sum_w + sssd_pkg::SUMW'(32768)) >> 16;
    if (sum_rnd > sssd_pkg::SUMW'(sssd_pkg::OUT_MAX)) begin
      dist_nxt = sssd_pkg::OUT_MAX;
    end else begin
      dist_nxt = sum_rnd[sssd_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS]) begin
      dist_r <= dist_nxt;
    end
  end

  assign out_squared_distance = dist_r;

  // checks
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r))
    else $error("input blocked while a stage is empty");

  a_div_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[ST_PRE] && !sdv_r[0].frc) |-> (sdv_r[0].rem < sdv_r[0].den))
    else $error("s divide started with numerator not below denominator");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (vld_r == '0))
    else $error("pipeline not empty after reset");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef logic signed [127:0] wide_t;
  // point order: first start xyz, first end xyz, second start xyz, second end xyz
  typedef struct packed {
    logic [11:0][sssd_pkg::CW-1:0] pt;
  } pair_t;

  localparam int DIR_N = 16;
  localparam int RAND_PER_PHASE = 125;
  localparam int PHASES = 6;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  pair_t pair_drv;
  logic out_valid;
  logic out_ready;
  logic [sssd_pkg::OUT_W-1:0] out_squared_distance;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [sssd_pkg::TW-1:0] par_thr;
  logic [sssd_pkg::TW-1:0] nz_thr;
  logic [sssd_pkg::OUT_W-1:0] distance_q[$];
  logic fixed_row;
  logic [sssd_pkg::OUT_W-1:0] fixed_distance;
  int errors;
  bit idle_on;
  bit hold_req;

  segment_segment_squared_distance_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_first_start_x    (pair_drv.pt[0]),
    .in_first_start_y    (pair_drv.pt[1]),
    .in_first_start_z    (pair_drv.pt[2]),
    .in_first_end_x      (pair_drv.pt[3]),
    .in_first_end_y      (pair_drv.pt[4]),
    .in_first_end_z      (pair_drv.pt[5]),
    .in_second_start_x   (pair_drv.pt[6]),
    .in_second_start_y   (pair_drv.pt[7]),
    .in_second_start_z   (pair_drv.pt[8]),
    .in_second_end_x     (pair_drv.pt[9]),
    .in_second_end_y     (pair_drv.pt[10]),
    .in_second_end_z     (pair_drv.pt[11]),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_squared_distance(out_squared_distance),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("segment_segment_squared_distance_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // parameter num/den in Q1.16 with snapping and clamping
  function automatic logic [sssd_pkg::SW-1:0] clamp_fraction(input wide_t num,
                                                             input wide_t den);
    wide_t mg;
    logic [sssd_pkg::SW-1:0] q;
    mg = num < 0 ? -num : num;
    q = '0;
    if (mg < wide_t'({1'b0, nz_thr})) return '0;
    if (den <= 0) return '0;
    if (num < 0) return '0;
    if (num >= den) return sssd_pkg::FRAC_ONE;
    for (int i = 0; i < sssd_pkg::QW; i++) begin
      num = num <<< 1;
      q = q << 1;
      if (num >= den) begin
        num = num - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // s when t sits at an end of the second segment
  function automatic void refit_first(input longint m, input longint uu,
                                      inout wide_t sn, inout wide_t sd);
    if (m < 0) sn = 0;
    else if (m > uu) sn = sd;
    else begin
      sn = wide_t'(m) <<< 16;
      sd = wide_t'(uu) <<< 16;
    end
  endfunction

  function automatic logic [sssd_pkg::OUT_W-1:0] squared_distance_of(input pair_t pr);
    longint u[3], v[3], w[3];
    longint uu, uv, vv, uw, vw, s, t, c;
    longint unsigned mg, sum;
    wide_t e, sn, sd, tn, td;
    uu = 0; uv = 0; vv = 0; uw = 0; vw = 0; sum = 0;
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'($signed(pr.pt[3+i])) - longint'($signed(pr.pt[i]));
      v[i] = longint'($signed(pr.pt[9+i])) - longint'($signed(pr.pt[6+i]));
      w[i] = longint'($signed(pr.pt[i])) - longint'($signed(pr.pt[6+i]));
      uu += u[i] * u[i];
      uv += u[i] * v[i];
      vv += v[i] * v[i];
      uw += u[i] * w[i];
      vw += v[i] * w[i];
    end
    e = wide_t'(uu) * wide_t'(vv) - wide_t'(uv) * wide_t'(uv);
    if (e < wide_t'({1'b0, par_thr})) begin
      sn = 0;
      sd = wide_t'(64'h1_0000_0000);
      tn = wide_t'(vw) <<< 16;
      td = wide_t'(vv) <<< 16;
    end else begin
      sd = e;
      td = e;
      sn = wide_t'(uv) * wide_t'(vw) - wide_t'(vv) * wide_t'(uw);
      tn = wide_t'(uu) * wide_t'(vw) - wide_t'(uv) * wide_t'(uw);
      if (sn < 0) begin
        sn = 0;
        tn = wide_t'(vw) <<< 16;
        td = wide_t'(vv) <<< 16;
      end else if (sd < sn) begin
        sn = sd;
        tn = wide_t'(vw + uv) <<< 16;
        td = wide_t'(vv) <<< 16;
      end
    end
    if (tn < 0) begin
      tn = 0;
      refit_first(-uw, uu, sn, sd);
    end else if (td < tn) begin
      tn = td;
      refit_first(uv - uw, uu, sn, sd);
    end
    s = longint'(clamp_fraction(sn, sd));
    t = longint'(clamp_fraction(tn, td));
    for (int i = 0; i < 3; i++) begin
      c = w[i] * 65536 + s * u[i] - t * v[i];
      mg = ((c < 0 ? -c : c) + 128) >> 8;
      sum += mg * mg;
    end
    sum = (sum + 32768) >> 16;
    if (sum > longint'(sssd_pkg::OUT_MAX)) sum = longint'(sssd_pkg::OUT_MAX);
    return sum[sssd_pkg::OUT_W-1:0];
  endfunction

  function automatic logic [sssd_pkg::CW-1:0] coord(input int span);
    if (span == 0) return sssd_pkg::CW'($urandom);
    return sssd_pkg::CW'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic pair_t random_pair();
    pair_t pr;
    int k;
    int kind;
    kind = $urandom_range(0, 6);
    for (int i = 0; i < 12; i++) pr.pt[i] = coord(kind == 0 ? 0 : 4096);
    case (kind)
      2: begin
        // one or both segments shrunk to a point
        k = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          if (k != 1) pr.pt[3+i] = pr.pt[i];
          if (k != 0) pr.pt[9+i] = pr.pt[6+i];
        end
      end
      3: begin
        // second segment along the first scaled by -1, 0, 1 or 2
        k = int'($urandom_range(0, 3)) - 1;
        for (int i = 0; i < 3; i++) begin
          pr.pt[6+i] = pr.pt[i] + coord(1024);
          pr.pt[9+i] = pr.pt[6+i]
                       + sssd_pkg::CW'(k * ($signed(pr.pt[3+i]) - $signed(pr.pt[i])));
        end
      end
      4: begin
        // shared end point
        k = $urandom_range(0, 1);
        for (int i = 0; i < 3; i++) pr.pt[6+i] = pr.pt[3*k+i];
      end
      5: begin
        for (int i = 0; i < 12; i++) begin
          case ($urandom_range(0, 3))
            0: pr.pt[i] = 16'h8000;
            1: pr.pt[i] = 16'h7fff;
            2: pr.pt[i] = '0;
            default: pr.pt[i] = coord(0);
          endcase
        end
      end
      6: for (int i = 0; i < 12; i++) pr.pt[i] = coord(4);
      default: ;
    endcase
    return pr;
  endfunction

  task automatic send_pair(input pair_t pr, input logic has_fixed,
                           input logic [sssd_pkg::OUT_W-1:0] fixed);
    @(negedge clk);
    pair_drv = pr;
    fixed_row = has_fixed;
    fixed_distance = fixed;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8) - 1) @(negedge clk);
    end
  endtask

  task automatic write_threshold(input sssd_pkg::reg_idx_t idx,
                                 input logic [sssd_pkg::TW-1:0] value);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == sssd_pkg::REG_PAR_THR) par_thr = value;
    else nz_thr = value;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== value) report_mismatch("register readback", prdata, value);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      if (fixed_row) distance_q.push_back(fixed_distance);
      else distance_q.push_back(squared_distance_of(pair_drv));
    end
    if (rst_n && out_valid && out_ready) begin
      if (distance_q.size() == 0) report_mismatch("unexpected beat", out_squared_distance, -1);
      else if (out_squared_distance !== distance_q[0]) begin
        report_mismatch("squared_distance", out_squared_distance, distance_q[0]);
        void'(distance_q.pop_front());
      end else void'(distance_q.pop_front());
    end
  end

  // result side: random stall bursts, plus one long hold to fill the pipeline
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (120) @(negedge clk);
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else out_ready = 1'b1;
    end
  end

  int dir_pts[DIR_N][12] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 256, 0, 0, 256, 0, 0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, 32767, 32767, 32767, 32767, 32767, 32767},
    '{32767, 32767, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768, -32768},
    '{-256, 0, 0, 256, 0, 0, 0, -256, 256, 0, 256, 256},
    '{0, 0, 0, 512, 0, 0, 128, 256, 0, 640, 256, 0},
    '{0, 0, 0, 256, 0, 0, -512, 100, 0, -512, 300, 50},
    '{0, 0, 0, 256, 0, 0, 900, -100, 30, 900, 300, 0},
    '{0, 0, 0, 256, 0, 0, 100, 300, 0, 200, 600, 0},
    '{0, 0, 0, 256, 0, 0, 100, -300, 0, 200, -600, 0},
    '{10, 20, 30, 10, 20, 30, -5, 7, 0, 300, 100, -40},
    '{-5, 7, 0, 300, 100, -40, 10, 20, 30, 10, 20, 30},
    '{0, 0, 0, 1, 1, 0, 1, 0, 0, 0, 1, 1},
    '{-32768, 0, 0, 32767, 0, 0, 0, -32768, 256, 0, 32767, 256},
    '{-32768, -32768, 32767, 32767, 32767, -32768, 32767, -32768, -32768, -32768, 32767, 32767},
    '{0, 0, 0, 256, 0, 0, 0, 0, 0, -256, 0, 0}
  };
  // -1 where the predictor supplies the expectation
  longint dir_expect[DIR_N] = '{0, 65536, 64'd12884508675, 64'd12884508675,
                                -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, 0};

  initial begin
    pair_t pr;
    logic [sssd_pkg::TW-1:0] par_set[PHASES];
    logic [sssd_pkg::TW-1:0] nz_set[PHASES];
    errors = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    in_valid = 1'b0;
    pair_drv = '0;
    fixed_row = 1'b0;
    fixed_distance = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    par_thr = sssd_pkg::PAR_THR_RST;
    nz_thr = sssd_pkg::NZ_THR_RST;
    par_set = '{sssd_pkg::PAR_THR_RST, '0, '1, '0, $urandom, sssd_pkg::PAR_THR_RST};
    nz_set = '{sssd_pkg::NZ_THR_RST, '0, '1, '1, $urandom_range(0, 1 << 20),
               sssd_pkg::NZ_THR_RST};
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIR_N; r++) begin
      for (int k = 0; k < 12; k++) pr.pt[k] = sssd_pkg::CW'(dir_pts[r][k]);
      send_pair(pr, dir_expect[r] >= 0, sssd_pkg::OUT_W'(dir_expect[r]));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        wait (distance_q.size() == 0);
        repeat (35) @(posedge clk);
        write_threshold(sssd_pkg::REG_PAR_THR, par_set[ph]);
        write_threshold(sssd_pkg::REG_NZ_THR, nz_set[ph]);
      end
      idle_on = (ph != PHASES - 1);
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        if (ph == 0 && n == 20) begin
          // sender runs flat out while the result side holds
          hold_req = 1'b1;
          idle_on = 1'b0;
        end
        if (ph == 0 && n == 60) idle_on = 1'b1;
        send_pair(random_pair(), 1'b0, '0);
      end
    end
    @(negedge clk);
    in_valid = 1'b0;
    wait (distance_q.size() == 0);
    repeat (40) @(posedge clk);
    if (errors == 0 && distance_q.size() == 0) begin
      $display("segment_segment_squared_distance_unit verification clean");
    end else begin
      $display("segment_segment_squared_distance_unit verification failed");
    end
    $finish;
  end

endmodule

>>> segment_segment_squared_distance_unit.f
hw/rtl/sssd_pkg.sv
hw/rtl/segment_segment_squared_distance_unit.sv
bench/testbench.sv
